@@ hdl/dwpd_pkg.sv @@
package dwpd_pkg;

    // Two wheels travel in every word; the field names fix the count.
    localparam int MOTOR_COUNT = 2;
    localparam int MOTOR_IDX_W = $clog2(MOTOR_COUNT);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Derating divides with one quotient bit per step.
    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_PROP  = 3'd0,
        CFG_GAIN_INTEG = 3'd1,
        CFG_GAIN_DERIV = 3'd2,
        CFG_INTEG_LIM  = 3'd3,
        CFG_CURR_LIM   = 3'd4,
        CFG_WARN       = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [23:0] gain_prop;
        logic [23:0] gain_integ;
        logic [23:0] gain_deriv;
        logic [13:0] integral_limit;
        logic [14:0] current_limit;
        logic [9:0]  warn_level;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        gain_prop:      24'd393216,
        gain_integ:     24'd1966,
        gain_deriv:     24'd131072,
        integral_limit: 14'd15000,
        current_limit:  15'd16384,
        warn_level:     10'd200
    };

    typedef struct packed {
        logic signed [15:0] target_a;
        logic signed [15:0] measured_a;
        logic signed [15:0] target_b;
        logic signed [15:0] measured_b;
        logic        [9:0]  buffer_energy;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] drive_a;
        logic signed [15:0] drive_b;
    } t_out_word;

    // Operand selection for the shared multiplier.
    typedef enum logic [2:0] {
        MS_NONE  = 3'd0,
        MS_PROP  = 3'd1,
        MS_INTEG = 3'd2,
        MS_DERIV = 3'd3,
        MS_DEN   = 3'd4,
        MS_NUM1  = 3'd5,
        MS_NUM2  = 3'd6
    } t_mul_sel;

    typedef struct packed {
        logic                   load;
        logic                   err_step;
        t_mul_sel               mul_sel;
        logic                   acc_add;
        logic                   sat_step;
        logic                   den_load;
        logic                   div_init;
        logic                   div_step;
        logic                   div_fin;
        logic [MOTOR_IDX_W-1:0] mot;
    } t_dp_cmd;

    typedef struct packed {
        logic derate;
    } t_dp_stat;

endpackage

@@ hdl/dual_wheel_pid_power_derate.sv @@
// An accepted input word is worked through both wheels before its result word
// is offered; when derating applies, each wheel also gets one 16-step divide.
// A new word is taken only after the previous result is handed on; the shared
// multiplier and the bit-serial divider are used by one word at a time.
// Reset is synchronous and active low; it restores the register defaults
// and clears both wheels' previous error and integral.
module dual_wheel_pid_power_derate import dwpd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_word             o_out_word,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg      r_cfg;
    logic      r_out_valid;
    t_out_word r_out_word;

    t_dp_cmd   w_cmd;
    t_dp_stat  w_stat;
    t_out_word w_drive_word;
    logic      w_out_load;
    logic      w_out_free;

    // The configuration port never pushes back. The user is to write only while no
    // word is in flight (the block does not enforce it), so no word sees half-written gains.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GAIN_PROP:  r_cfg.gain_prop      <= i_cfg_data;
                CFG_GAIN_INTEG: r_cfg.gain_integ     <= i_cfg_data;
                CFG_GAIN_DERIV: r_cfg.gain_deriv     <= i_cfg_data;
                CFG_INTEG_LIM:  r_cfg.integral_limit <= i_cfg_data[13:0];
                CFG_CURR_LIM:   r_cfg.current_limit  <= i_cfg_data[14:0];
                CFG_WARN:       r_cfg.warn_level     <= i_cfg_data[9:0];
                default: begin
                end
            endcase
        end
    end

    // The output register decouples the two sides: the next input word can
    // be taken and worked on while the previous result still waits here.
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_word <= w_drive_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // The controller steps each wheel through error, three multiply and
    // accumulate passes and saturation, then optionally the derating
    // multiply and divide, and finally hands the pair to the output register.
    dwpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (w_out_free),
        .i_stat     (w_stat),
        .o_in_stall (o_in_stall),
        .o_out_load (w_out_load),
        .o_cmd      (w_cmd)
    );

    dwpd_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_word    (i_in_word),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_drive_word (w_drive_word)
    );

`ifndef SYNTHESIS
    a_out_rise_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_out_load))
        else $error("result word appeared without a load");

    a_no_accept_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |-> !w_out_load)
        else $error("input word accepted while a result is being loaded");

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> w_out_free)
        else $error("result loaded over a waiting result");
`endif

endmodule

@@ hdl/dwpd_ctrl.sv @@
module dwpd_ctrl import dwpd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_out_free,
    input  t_dp_stat i_stat,
    output logic     o_in_stall,
    output logic     o_out_load,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_ERR  = 14'b00000000000010,
        S_MP   = 14'b00000000000100,
        S_MI   = 14'b00000000001000,
        S_MD   = 14'b00000000010000,
        S_ADD  = 14'b00000000100000,
        S_SAT  = 14'b00000001000000,
        S_DEN  = 14'b00000010000000,
        S_NUM1 = 14'b00000100000000,
        S_NUM2 = 14'b00001000000000,
        S_DIVI = 14'b00010000000000,
        S_DIV  = 14'b00100000000000,
        S_FIN  = 14'b01000000000000,
        S_OUT  = 14'b10000000000000
    } t_state;

    localparam logic [MOTOR_IDX_W-1:0] MOT_LAST = MOTOR_IDX_W'(MOTOR_COUNT - 1);
    localparam logic [DIV_CNT_W-1:0]   CNT_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    t_state                 r_state, n_state;
    logic [MOTOR_IDX_W-1:0] r_mot, n_mot;
    logic [DIV_CNT_W-1:0]   r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mot   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_mot   <= n_mot;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_mot      = r_mot;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_cmd.mot  = r_mot;
        o_out_load = 1'b0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_mot      = '0;
                    n_state    = S_ERR;
                end
            end
            S_ERR: begin
                o_cmd.err_step = 1'b1;
                n_state        = S_MP;
            end
            S_MP: begin
                o_cmd.mul_sel = MS_PROP;
                n_state       = S_MI;
            end
            S_MI: begin
                o_cmd.mul_sel = MS_INTEG;
                o_cmd.acc_add = 1'b1;
                n_state       = S_MD;
            end
            S_MD: begin
                o_cmd.mul_sel = MS_DERIV;
                o_cmd.acc_add = 1'b1;
                n_state       = S_ADD;
            end
            S_ADD: begin
                o_cmd.acc_add = 1'b1;
                n_state       = S_SAT;
            end
            S_SAT: begin
                o_cmd.sat_step = 1'b1;
                if (r_mot == MOT_LAST) begin
                    n_mot   = '0;
                    n_state = i_stat.derate ? S_DEN : S_OUT;
                end else begin
                    n_mot   = r_mot + 1'b1;
                    n_state = S_ERR;
                end
            end
            S_DEN: begin
                o_cmd.mul_sel = MS_DEN;
                n_state       = S_NUM1;
            end
            S_NUM1: begin
                // The squared warning energy sits in the product register
                // only ahead of the first wheel.
                o_cmd.den_load = (r_mot == '0);
                o_cmd.mul_sel  = MS_NUM1;
                n_state        = S_NUM2;
            end
            S_NUM2: begin
                o_cmd.mul_sel = MS_NUM2;
                n_state       = S_DIVI;
            end
            S_DIVI: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.div_fin = 1'b1;
                if (r_mot == MOT_LAST) begin
                    n_mot   = '0;
                    n_state = S_OUT;
                end else begin
                    n_mot   = r_mot + 1'b1;
                    n_state = S_NUM1;
                end
            end
            S_OUT: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/dwpd_dpath.sv @@
module dwpd_dpath import dwpd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_in_word  i_in_word,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    output t_out_word o_drive_word
);

    t_in_word           r_in;
    logic signed [16:0] r_prev [MOTOR_COUNT];
    logic signed [14:0] r_esum [MOTOR_COUNT];
    logic signed [15:0] r_drive [MOTOR_COUNT];

    logic signed [16:0] r_err;
    logic signed [17:0] r_derr;
    logic signed [14:0] r_sumv;
    logic signed [43:0] r_prod;
    logic signed [43:0] r_acc;
    logic        [19:0] r_den;
    logic        [19:0] r_rem;
    logic        [15:0] r_nlo;
    logic        [15:0] r_quo;

    logic signed [15:0] w_tgt [MOTOR_COUNT];
    logic signed [15:0] w_meas [MOTOR_COUNT];
    logic signed [16:0] w_err;
    logic signed [17:0] w_derr;
    logic signed [17:0] w_sum_raw;
    logic signed [17:0] w_ilim;
    logic signed [14:0] w_sum_new;
    logic        [24:0] w_mul_a;
    logic signed [17:0] w_mul_b;
    logic signed [43:0] w_prod;
    logic signed [43:0] w_acc_adj;
    logic signed [27:0] w_quot;
    logic signed [27:0] w_clim;
    logic signed [15:0] w_sat;
    logic signed [15:0] w_drv_sel;
    logic signed [15:0] w_drv_neg;
    logic        [14:0] w_mag;
    logic        [20:0] w_trial;
    logic        [20:0] w_den_ext;
    logic               w_ge;

    always_comb begin
        w_tgt[0]  = r_in.target_a;
        w_meas[0] = r_in.measured_a;
        w_tgt[1]  = r_in.target_b;
        w_meas[1] = r_in.measured_b;
    end

    assign o_stat.derate = (r_in.buffer_energy != '0) &&
                           (r_in.buffer_energy < i_cfg.warn_level);

    // Error, derivative and clamped integral of the selected wheel.
    always_comb begin
        w_err     = {w_tgt[i_cmd.mot][15], w_tgt[i_cmd.mot]}
                  - {w_meas[i_cmd.mot][15], w_meas[i_cmd.mot]};
        w_derr    = {w_err[16], w_err} - {r_prev[i_cmd.mot][16], r_prev[i_cmd.mot]};
        w_sum_raw = {{3{r_esum[i_cmd.mot][14]}}, r_esum[i_cmd.mot]}
                  + {w_err[16], w_err};
        w_ilim    = {4'b0, i_cfg.integral_limit};
        if (w_sum_raw > w_ilim) begin
            w_sum_new = w_ilim[14:0];
        end else if (w_sum_raw < -w_ilim) begin
            w_sum_new = 15'(-w_ilim);
        end else begin
            w_sum_new = w_sum_raw[14:0];
        end
    end

    assign w_drv_sel = r_drive[i_cmd.mot];
    assign w_drv_neg = -w_drv_sel;
    assign w_mag     = w_drv_sel[15] ? w_drv_neg[14:0] : w_drv_sel[14:0];

    always_comb begin
        case (i_cmd.mul_sel)
            MS_PROP: begin
                w_mul_a = {1'b0, i_cfg.gain_prop};
                w_mul_b = {r_err[16], r_err};
            end
            MS_INTEG: begin
                w_mul_a = {1'b0, i_cfg.gain_integ};
                w_mul_b = {{3{r_sumv[14]}}, r_sumv};
            end
            MS_DERIV: begin
                w_mul_a = {1'b0, i_cfg.gain_deriv};
                w_mul_b = r_derr;
            end
            MS_DEN: begin
                w_mul_a = {15'b0, i_cfg.warn_level};
                w_mul_b = {8'b0, i_cfg.warn_level};
            end
            MS_NUM1: begin
                w_mul_a = {10'b0, w_mag};
                w_mul_b = {8'b0, r_in.buffer_energy};
            end
            MS_NUM2: begin
                w_mul_a = r_prod[24:0];
                w_mul_b = {8'b0, r_in.buffer_energy};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = $signed({1'b0, w_mul_a}) * w_mul_b;

    // Divide by 65536 toward zero, then saturate.
    assign w_acc_adj = r_acc + (r_acc[43] ? 44'sd65535 : 44'sd0);
    assign w_quot    = w_acc_adj[43:16];
    assign w_clim    = {13'b0, i_cfg.current_limit};

    always_comb begin
        if (w_quot > w_clim) begin
            w_sat = w_clim[15:0];
        end else if (w_quot < -w_clim) begin
            w_sat = 16'(-w_clim);
        end else begin
            w_sat = w_quot[15:0];
        end
    end

    assign w_den_ext = {1'b0, r_den};
    assign w_trial   = {r_rem, r_nlo[15]};
    assign w_ge      = (w_trial >= w_den_ext);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MOTOR_COUNT; i++) begin
                r_prev[i] <= '0;
                r_esum[i] <= '0;
            end
        end else if (i_cmd.err_step) begin
            r_prev[i_cmd.mot] <= w_err;
            r_esum[i_cmd.mot] <= w_sum_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in_word;
        end
        if (i_cmd.err_step) begin
            r_err  <= w_err;
            r_derr <= w_derr;
            r_sumv <= w_sum_new;
        end
        if (i_cmd.mul_sel != MS_NONE) begin
            r_prod <= w_prod;
        end
        if (i_cmd.err_step) begin
            r_acc <= '0;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + r_prod;
        end
        if (i_cmd.den_load) begin
            r_den <= r_prod[19:0];
        end
        if (i_cmd.div_init) begin
            r_rem <= {1'b0, r_prod[34:16]};
            r_nlo <= r_prod[15:0];
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? 20'(w_trial - w_den_ext) : w_trial[19:0];
            r_nlo <= {r_nlo[14:0], 1'b0};
            r_quo <= {r_quo[14:0], w_ge};
        end
        if (i_cmd.sat_step) begin
            r_drive[i_cmd.mot] <= w_sat;
        end else if (i_cmd.div_fin) begin
            r_drive[i_cmd.mot] <= w_drv_sel[15] ? -$signed(r_quo) : $signed(r_quo);
        end
    end

    assign o_drive_word.drive_a = r_drive[0];
    assign o_drive_word.drive_b = r_drive[1];

`ifndef SYNTHESIS
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");

    a_derate_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_fin |-> ({1'b0, r_quo} <= {2'b0, w_mag}))
        else $error("derated drive larger than undarated drive");
`endif

endmodule
